// ===== rtl/core/wse_pkg.sv =====
// ----------------------------------------------------------------------------
// wse_pkg
// Shared types and constants of the wheel speed estimator: commands,
// register indexes, configuration set and the word passed to the back end.
// ----------------------------------------------------------------------------
package wse_pkg;

  localparam int CMD_W       = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int GAIN_W      = 24;
  localparam int DEADBAND_W  = 15;
  localparam int THR_W       = 14;
  localparam int SPEED_W     = 16;
  localparam int KNOB_W      = 4;
  // Widest unwrapped angle delta (angle width up to 16 bits, plus sign).
  localparam int DELTA_W     = 17;
  localparam int Q_SHIFT     = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [GAIN_W-1:0]     GAIN_RST     = 24'd65536;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 15'd30;
  localparam logic [THR_W-1:0]      UNWRAP_RST   = 14'd13653;
  localparam logic [THR_W-1:0]      KNOB_RST     = 14'd13653;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE      = 2'd0,
    CMD_SAMPLE_KNOB = 2'd1,
    CMD_CLEAR       = 2'd2,
    CMD_NONE        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED_GAIN = 2'd0,
    REG_DEADBAND   = 2'd1,
    REG_UNWRAP_THR = 2'd2,
    REG_KNOB_THR   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]     speed_gain;
    logic [DEADBAND_W-1:0] deadband;
    logic [THR_W-1:0]      unwrap_thr;
    logic [THR_W-1:0]      knob_thr;
  } cfg_t;

  typedef struct packed {
    cmd_t                      kind;
    logic signed [DELTA_W-1:0] d_right;
    logic signed [DELTA_W-1:0] d_left;
    logic [KNOB_W-1:0]         knob_number;
    logic [KNOB_W-1:0]         knob_mode;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/wse_if.sv =====
// ----------------------------------------------------------------------------
// wse channel interfaces
// Valid/ready channels for sample ticks in and averaged speeds out.
// ----------------------------------------------------------------------------
interface wse_in_if import wse_pkg::*; #(parameter int ANGLE_BITS = 14) ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [ANGLE_BITS-1:0] angle_right;
  logic [ANGLE_BITS-1:0] angle_left;

  modport source (output valid, output cmd, output angle_right, output angle_left,
                  input ready);
  modport sink   (input valid, input cmd, input angle_right, input angle_left,
                  output ready);
endinterface

interface wse_out_if import wse_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_right;
  logic signed [SPEED_W-1:0] speed_left;
  logic [KNOB_W-1:0]         knob_number;
  logic [KNOB_W-1:0]         knob_mode;

  modport source (output valid, output speed_right, output speed_left,
                  output knob_number, output knob_mode, input ready);
  modport sink   (input valid, input speed_right, input speed_left,
                  input knob_number, input knob_mode, output ready);
endinterface

// ===== rtl/core/wse_front.sv =====
// ----------------------------------------------------------------------------
// wse_front
// Accepts sample ticks, unwraps angle deltas and runs the knob counters.
// ----------------------------------------------------------------------------
module wse_front import wse_pkg::*; #(
  parameter int ANGLE_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_acc,
  input  cmd_t                  cmd,
  input  logic [ANGLE_BITS-1:0] angle_right,
  input  logic [ANGLE_BITS-1:0] angle_left,
  output logic                  push,
  output work_t                 push_data
);

  localparam int D_W   = ANGLE_BITS + 1;
  localparam int C_W   = ((ANGLE_BITS > THR_W) ? ANGLE_BITS : THR_W) + 2;
  localparam int ACC_W = C_W;

  logic [ANGLE_BITS-1:0]     last_right_r, last_right_nxt;
  logic [ANGLE_BITS-1:0]     last_left_r, last_left_nxt;
  logic signed [ACC_W-1:0]   acc_right_r, acc_right_nxt;
  logic signed [ACC_W-1:0]   acc_left_r, acc_left_nxt;
  logic [KNOB_W-1:0]         number_r, number_nxt;
  logic [KNOB_W-1:0]         mode_r, mode_nxt;
  logic signed [D_W-1:0]     d_right, d_left;

  function automatic logic signed [D_W-1:0] unwrap(
    input logic [ANGLE_BITS-1:0] now,
    input logic [ANGLE_BITS-1:0] prev,
    input logic [THR_W-1:0]      thr
  );
    logic signed [C_W-1:0] d;
    logic signed [C_W-1:0] t;
    logic signed [C_W-1:0] r;
    d = $signed(C_W'(now)) - $signed(C_W'(prev));
    t = $signed(C_W'(thr));
    r = d;
    if (d < -t) begin
      r = d + $signed(C_W'(1) << ANGLE_BITS);
    end else if (d > t) begin
      r = d - $signed(C_W'(1) << ANGLE_BITS);
    end
    return $signed(r[D_W-1:0]);
  endfunction

  // Returns {counter, accumulator}.
  function automatic logic [KNOB_W+ACC_W-1:0] knob_step(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [D_W-1:0]   d,
    input logic [KNOB_W-1:0]       cnt,
    input logic                    up_fwd,
    input logic [THR_W-1:0]        thr
  );
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] t;
    logic [KNOB_W-1:0]       c;
    a = acc + ACC_W'(d);
    t = $signed(ACC_W'(thr));
    c = cnt;
    if (a > t) begin
      c = up_fwd ? cnt + 1'b1 : cnt - 1'b1;
      a = '0;
    end else if (a < -t) begin
      c = up_fwd ? cnt - 1'b1 : cnt + 1'b1;
      a = '0;
    end
    return {c, a};
  endfunction

  always_comb begin
    d_right        = unwrap(angle_right, last_right_r, cfg.unwrap_thr);
    d_left         = unwrap(angle_left, last_left_r, cfg.unwrap_thr);
    last_right_nxt = last_right_r;
    last_left_nxt  = last_left_r;
    acc_right_nxt  = acc_right_r;
    acc_left_nxt   = acc_left_r;
    number_nxt     = number_r;
    mode_nxt       = mode_r;
    unique case (cmd)
      CMD_SAMPLE: begin
        last_right_nxt = angle_right;
        last_left_nxt  = angle_left;
      end
      CMD_SAMPLE_KNOB: begin
        last_right_nxt              = angle_right;
        last_left_nxt               = angle_left;
        {number_nxt, acc_right_nxt} = knob_step(acc_right_r, d_right, number_r, 1'b0,
                                                cfg.knob_thr);
        {mode_nxt, acc_left_nxt}    = knob_step(acc_left_r, d_left, mode_r, 1'b1,
                                                cfg.knob_thr);
      end
      CMD_CLEAR: begin
        acc_right_nxt = '0;
        acc_left_nxt  = '0;
        number_nxt    = '0;
        mode_nxt      = '0;
      end
      CMD_NONE: begin
      end
    endcase
  end

  assign push      = in_acc;
  assign push_data = '{kind:        cmd,
                       d_right:     DELTA_W'(d_right),
                       d_left:      DELTA_W'(d_left),
                       knob_number: number_nxt,
                       knob_mode:   mode_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_right_r <= '0;
      last_left_r  <= '0;
      acc_right_r  <= '0;
      acc_left_r   <= '0;
      number_r     <= '0;
      mode_r       <= '0;
    end else if (in_acc) begin
      last_right_r <= last_right_nxt;
      last_left_r  <= last_left_nxt;
      acc_right_r  <= acc_right_nxt;
      acc_left_r   <= acc_left_nxt;
      number_r     <= number_nxt;
      mode_r       <= mode_nxt;
    end
  end

endmodule

// ===== rtl/core/wse_queue.sv =====
// ----------------------------------------------------------------------------
// wse_queue
// Short FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module wse_queue import wse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  work_t     push_data,
  input  logic      pop,
  output work_t     head,
  output q_status_t q_stat
);

  work_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W:0]   cnt_r;

  assign head         = mem_r[rd_r];
  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/wse_lane.sv =====
// ----------------------------------------------------------------------------
// wse_lane
// Speed pipeline of one wheel: gain multiply, truncate, saturate, deadband,
// moving-average window and constant divide by the tap count.
// ----------------------------------------------------------------------------
module wse_lane import wse_pkg::*; #(
  parameter int TAPS   = 20,
  parameter bit NEGATE = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      push,
  input  logic [GAIN_W-1:0]         gain,
  input  logic [DEADBAND_W-1:0]     deadband,
  input  logic signed [DELTA_W-1:0] delta,
  output logic signed [SPEED_W-1:0] avg
);

  localparam int P_W     = DELTA_W + GAIN_W + 1;
  localparam int T_W     = P_W - Q_SHIFT;
  localparam int SUM_W   = SPEED_W + $clog2(TAPS) + 1;
  localparam int MAG_W   = SUM_W - 1;
  localparam int K       = MAG_W + $clog2(TAPS);
  localparam int RECIP_W = MAG_W + 2;
  localparam int QP_W    = MAG_W + RECIP_W;
  localparam int QUO_W   = SPEED_W + 1;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << K) + longint'(TAPS) - 1) / longint'(TAPS);
  localparam logic [RECIP_W-1:0]      RECIP   = RECIP_W'(RECIP_L);
  localparam logic signed [P_W-1:0]   RND     = P_W'((1 << Q_SHIFT) - 1);
  localparam logic signed [P_W-1:0]   P_ZERO  = '0;
  localparam logic signed [T_W-1:0]   SAT_HI  = T_W'(32767);
  localparam logic signed [T_W-1:0]   SAT_LO  = T_W'(-32768);
  localparam logic signed [SPEED_W-1:0] SPD_HI = 16'sh7FFF;
  localparam logic signed [SPEED_W-1:0] SPD_LO = 16'sh8000;

  logic signed [GAIN_W:0]    gain_eff_r, gain_eff_nxt;
  logic signed [P_W-1:0]     p_r;
  logic signed [P_W-1:0]     p_biased;
  logic signed [T_W-1:0]     t_r;
  logic signed [T_W-1:0]     t_mag;
  logic signed [T_W-1:0]     db_s;
  logic signed [SPEED_W-1:0] spd_r, spd_nxt;
  logic signed [SPEED_W-1:0] hist_r [TAPS];
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic [QP_W-1:0]           qp;
  logic [QUO_W-1:0]          q_r;
  logic                      sign_r;

  // Gain folds in right negation; user changes gain only while idle, unchecked.
  always_comb begin
    gain_eff_nxt = $signed({1'b0, gain});
    if (NEGATE) begin
      gain_eff_nxt = -$signed({1'b0, gain});
    end
  end

  always_ff @(posedge clk) begin
    gain_eff_r <= gain_eff_nxt;
  end

  // Truncate toward zero: bias negative products before the shift.
  assign p_biased = p_r + (p_r[P_W-1] ? RND : P_ZERO);

  always_comb begin
    t_mag   = t_r[T_W-1] ? -t_r : t_r;
    db_s    = $signed(T_W'(deadband));
    spd_nxt = t_r[SPEED_W-1:0];
    if (t_r > SAT_HI) begin
      spd_nxt = SPD_HI;
    end else if (t_r < SAT_LO) begin
      spd_nxt = SPD_LO;
    end else if (t_mag < db_s) begin
      spd_nxt = '0;
    end
  end

  assign sum_nxt = sum_r - SUM_W'(hist_r[TAPS-1]) + SUM_W'(spd_r);
  assign qp      = mag_r * RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= delta * gain_eff_r;
      t_r    <= $signed(p_biased[P_W-1:Q_SHIFT]);
      spd_r  <= spd_nxt;
      neg_r  <= sum_r[SUM_W-1];
      mag_r  <= sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
      q_r    <= QUO_W'(qp >> K);
      sign_r <= neg_r;
    end
  end

  // Window delay line and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (push) begin
      for (int i = TAPS - 1; i > 0; i--) begin
        hist_r[i] <= hist_r[i-1];
      end
      hist_r[0] <= spd_r;
      sum_r     <= sum_nxt;
    end
  end

  assign avg = sign_r ? $signed(-q_r[SPEED_W-1:0]) : $signed(q_r[SPEED_W-1:0]);

endmodule

// ===== rtl/core/wse_back.sv =====
// ----------------------------------------------------------------------------
// wse_back
// Executes queued words through both wheel lanes and holds the output word.
// ----------------------------------------------------------------------------
module wse_back import wse_pkg::*; #(
  parameter int TAPS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  work_t                     head,
  input  q_status_t                 q_stat,
  output logic                      pop,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic signed [SPEED_W-1:0] speed_right,
  output logic signed [SPEED_W-1:0] speed_left,
  output logic [KNOB_W-1:0]         knob_number,
  output logic [KNOB_W-1:0]         knob_mode
);

  localparam int BACK_STAGES = 6;
  // Stage whose word is written into the averaging window on advance.
  localparam int PUSH_STAGE  = 2;

  typedef struct packed {
    logic              valid;
    cmd_t              kind;
    logic [KNOB_W-1:0] knob_number;
    logic [KNOB_W-1:0] knob_mode;
  } stage_tag_t;

  stage_tag_t                tag_r [BACK_STAGES];
  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] speed_right_r, speed_left_r;
  logic [KNOB_W-1:0]         knob_number_r, knob_mode_r;
  logic signed [SPEED_W-1:0] avg_right, avg_left;
  logic                      en;
  logic                      win_push;

  assign en       = !out_valid_r || out_ready;
  assign pop      = en && !q_stat.empty;
  assign win_push = en && tag_r[PUSH_STAGE].valid &&
                    ((tag_r[PUSH_STAGE].kind == CMD_SAMPLE) ||
                     (tag_r[PUSH_STAGE].kind == CMD_SAMPLE_KNOB));

  wse_lane #(.TAPS(TAPS), .NEGATE(1'b1)) u_lane_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .push     (win_push),
    .gain     (cfg.speed_gain),
    .deadband (cfg.deadband),
    .delta    (head.d_right),
    .avg      (avg_right)
  );

  wse_lane #(.TAPS(TAPS), .NEGATE(1'b0)) u_lane_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .push     (win_push),
    .gain     (cfg.speed_gain),
    .deadband (cfg.deadband),
    .delta    (head.d_left),
    .avg      (avg_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_STAGES; i++) begin
        tag_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      tag_r[0] <= '{valid:       !q_stat.empty,
                    kind:        head.kind,
                    knob_number: head.knob_number,
                    knob_mode:   head.knob_mode};
      for (int i = 1; i < BACK_STAGES; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      out_valid_r <= tag_r[BACK_STAGES-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tag_r[BACK_STAGES-1].valid) begin
      speed_right_r <= avg_right;
      speed_left_r  <= avg_left;
      knob_number_r <= tag_r[BACK_STAGES-1].knob_number;
      knob_mode_r   <= tag_r[BACK_STAGES-1].knob_mode;
    end
  end

  assign out_valid   = out_valid_r;
  assign speed_right = speed_right_r;
  assign speed_left  = speed_left_r;
  assign knob_number = knob_number_r;
  assign knob_mode   = knob_mode_r;

endmodule

// ===== rtl/core/wheel_speed_estimator_core.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_estimator_core
// Two-wheel speed estimator with moving average and knob counters.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample tick per word: cmd plus the right and left
//   absolute angle counts. out_ch returns exactly one word per input word:
//   the averaged right and left speeds in mm/s and the two knob counters.
//   cfg_we/cfg_index/cfg_data write gain, deadband and the two thresholds;
//   write them only while no word is in flight.
// Throughput:
//   An accepted word passes through the queue, the back pipeline stages and
//   the output register before it shows on out_ch. While the receiver keeps
//   up, one word per cycle is sustained: each wheel has one multiplier stage
//   and a running window sum, so nothing iterates.
// Reset:
//   rst_n clears the previous angles, both averaging windows and sums, the
//   knob accumulators and counters, and loads the register defaults.
// Stall:
//   While out_ch is held, the back pipeline freezes and the four-word queue
//   keeps taking input; in_ch.ready drops once the queue is full.
module wheel_speed_estimator_core import wse_pkg::*; #(
  parameter int TAPS       = 20,
  parameter int ANGLE_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wse_in_if.sink                in_ch,
  wse_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  logic      in_acc;
  logic      push;
  logic      pop;
  work_t     push_data;
  work_t     head;
  q_status_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{speed_gain: GAIN_RST,
                 deadband:   DEADBAND_RST,
                 unwrap_thr: UNWRAP_RST,
                 knob_thr:   KNOB_RST};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SPEED_GAIN: cfg_r.speed_gain <= cfg_data[GAIN_W-1:0];
        REG_DEADBAND:   cfg_r.deadband   <= cfg_data[DEADBAND_W-1:0];
        REG_UNWRAP_THR: cfg_r.unwrap_thr <= cfg_data[THR_W-1:0];
        REG_KNOB_THR:   cfg_r.knob_thr   <= cfg_data[THR_W-1:0];
      endcase
    end
  end

  // Take a word whenever the queue has room.
  assign in_ch.ready = !q_stat.full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  wse_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_acc      (in_acc),
    .cmd         (cmd_t'(in_ch.cmd)),
    .angle_right (in_ch.angle_right),
    .angle_left  (in_ch.angle_left),
    .push        (push),
    .push_data   (push_data)
  );

  wse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  wse_back #(.TAPS(TAPS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .speed_right (out_ch.speed_right),
    .speed_left  (out_ch.speed_left),
    .knob_number (out_ch.knob_number),
    .knob_mode   (out_ch.knob_mode)
  );

endmodule

// ===== rtl/core/wse_checker.sv =====
// ----------------------------------------------------------------------------
// wse_checker
// Port-level checks of the wheel speed estimator, bound to the top level.
// ----------------------------------------------------------------------------
module wse_checker import wse_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SPEED_W-1:0] speed_right,
  input logic signed [SPEED_W-1:0] speed_left,
  input logic [KNOB_W-1:0]         knob_number,
  input logic [KNOB_W-1:0]         knob_mode
);

  // Reset empties the output stage.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // Reset empties the queue, so input is taken right away.
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low right after reset");

  // No word can cross the queue and back pipeline faster than its depth.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid
                     ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result word appeared too soon after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(speed_right) &&
    $stable(speed_left) && $stable(knob_number) && $stable(knob_mode))
    else $error("stalled result word changed");

endmodule

bind wheel_speed_estimator_core wse_checker u_wse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .speed_right (out_ch.speed_right),
  .speed_left  (out_ch.speed_left),
  .knob_number (out_ch.knob_number),
  .knob_mode   (out_ch.knob_mode)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: wheel speed estimator core
// Drives sample ticks with bursty valid and a stalling receiver, predicts
// each averaged speed and knob word in a behavioral model of the two wheels,
// and checks every output word in order across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import wse_pkg::*;

  localparam int TAPS           = 20;
  localparam int ANGLE_BITS     = 14;
  localparam int TURN           = 1 << ANGLE_BITS;
  localparam int RIGHT          = 0;
  localparam int LEFT           = 1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 30;

  // One output word as the block returns it.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [SPEED_W-1:0] speed_left;
    logic [KNOB_W-1:0]         knob_number;
    logic [KNOB_W-1:0]         knob_mode;
  } speed_word_t;

  // --------------------------------------------------------------------------
  // Behavioral model of both wheels plus the words still owed by the block.
  // --------------------------------------------------------------------------
  class wheel_state;
    logic [GAIN_W-1:0]     gain;
    logic [DEADBAND_W-1:0] deadband;
    logic [THR_W-1:0]      unwrap_thr;
    logic [THR_W-1:0]      knob_thr;
    logic [ANGLE_BITS-1:0] last_angle [2];
    int                    history [2][TAPS];
    int                    window_sum [2];
    int                    knob_accum [2];
    logic [KNOB_W-1:0]     knob_number;
    logic [KNOB_W-1:0]     knob_mode;
    speed_word_t           owed_words [$];
    int                    mismatch_count;
    int                    words_checked;

    function new();
      gain        = GAIN_RST;
      deadband    = DEADBAND_RST;
      unwrap_thr  = UNWRAP_RST;
      knob_thr    = KNOB_RST;
      knob_number = '0;
      knob_mode   = '0;
      for (int w = 0; w < 2; w++) begin
        last_angle[w] = '0;
        window_sum[w] = 0;
        knob_accum[w] = 0;
        for (int i = 0; i < TAPS; i++) history[w][i] = 0;
      end
      mismatch_count = 0;
      words_checked  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SPEED_GAIN: gain       = value[GAIN_W-1:0];
        REG_DEADBAND:   deadband   = value[DEADBAND_W-1:0];
        REG_UNWRAP_THR: unwrap_thr = value[THR_W-1:0];
        REG_KNOB_THR:   knob_thr   = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unwrap(logic [ANGLE_BITS-1:0] now_angle, logic [ANGLE_BITS-1:0] prev);
      int d;
      d = int'(now_angle) - int'(prev);
      if (d < -int'(unwrap_thr))
        d += TURN;
      else if (d > int'(unwrap_thr))
        d -= TURN;
      return d;
    endfunction

    // Scale by the Q16 gain, truncate toward zero, saturate, then apply deadband.
    function int tick_speed(int delta, bit negate);
      longint prod;
      longint s;
      longint mag;
      prod = longint'(delta) * longint'(gain);
      s = prod / (longint'(1) <<< Q_SHIFT);
      if (negate) s = -s;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      mag = (s < 0) ? -s : s;
      if (mag < longint'(deadband)) s = 0;
      return int'(s);
    endfunction

    function void push_window(int w, int v);
      window_sum[w] -= history[w][TAPS-1];
      for (int i = TAPS - 1; i > 0; i--) history[w][i] = history[w][i-1];
      history[w][0] = v;
      window_sum[w] += v;
    endfunction

    // Left steps up on forward rotation, right steps down.
    function void knob_step(int w, int delta);
      int thr;
      thr = int'(knob_thr);
      knob_accum[w] += delta;
      if (knob_accum[w] > thr) begin
        if (w == LEFT) knob_mode = knob_mode + 1'b1;
        else knob_number = knob_number - 1'b1;
        knob_accum[w] = 0;
      end else if (knob_accum[w] < -thr) begin
        if (w == LEFT) knob_mode = knob_mode - 1'b1;
        else knob_number = knob_number + 1'b1;
        knob_accum[w] = 0;
      end
    endfunction

    function void take_tick(cmd_t cmd, logic [ANGLE_BITS-1:0] ar, logic [ANGLE_BITS-1:0] al);
      int          dr;
      int          dl;
      speed_word_t word;
      if (cmd == CMD_SAMPLE || cmd == CMD_SAMPLE_KNOB) begin
        dr = unwrap(ar, last_angle[RIGHT]);
        dl = unwrap(al, last_angle[LEFT]);
        last_angle[RIGHT] = ar;
        last_angle[LEFT]  = al;
        push_window(RIGHT, tick_speed(dr, 1'b1));
        push_window(LEFT, tick_speed(dl, 1'b0));
        if (cmd == CMD_SAMPLE_KNOB) begin
          knob_step(RIGHT, dr);
          knob_step(LEFT, dl);
        end
      end else if (cmd == CMD_CLEAR) begin
        knob_accum[RIGHT] = 0;
        knob_accum[LEFT]  = 0;
        knob_number       = '0;
        knob_mode         = '0;
      end
      word.speed_right = SPEED_W'(window_sum[RIGHT] / TAPS);
      word.speed_left  = SPEED_W'(window_sum[LEFT] / TAPS);
      word.knob_number = knob_number;
      word.knob_mode   = knob_mode;
      owed_words.push_back(word);
    endfunction

    task flag_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task match_word(speed_word_t got);
      speed_word_t want;
      if (owed_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word right=%0d left=%0d number=%0d mode=%0d",
                                got.speed_right, got.speed_left, got.knob_number,
                                got.knob_mode));
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      if (got.speed_right !== want.speed_right)
        flag_mismatch($sformatf("word %0d speed_right %0d, want %0d", words_checked,
                                got.speed_right, want.speed_right));
      if (got.speed_left !== want.speed_left)
        flag_mismatch($sformatf("word %0d speed_left %0d, want %0d", words_checked,
                                got.speed_left, want.speed_left));
      if (got.knob_number !== want.knob_number)
        flag_mismatch($sformatf("word %0d knob_number %0d, want %0d", words_checked,
                                got.knob_number, want.knob_number));
      if (got.knob_mode !== want.knob_mode)
        flag_mismatch($sformatf("word %0d knob_mode %0d, want %0d", words_checked,
                                got.knob_mode, want.knob_mode));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #6 clk = ~clk;

  wse_in_if #(.ANGLE_BITS(ANGLE_BITS)) in_ch ();
  wse_out_if out_ch ();

  wheel_speed_estimator_core #(
    .TAPS       (TAPS),
    .ANGLE_BITS (ANGLE_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wheel_state            wheels;
  logic [ANGLE_BITS-1:0] pos_right;     // last angle sent, right wheel
  logic [ANGLE_BITS-1:0] pos_left;      // last angle sent, left wheel
  int                    ticks_by_cmd [4];
  int                    settings_used;
  int                    idle_cycles;
  logic [15:0]           stall_pattern;
  int                    stall_phase = 0;

  // --------------------------------------------------------------------------
  // Receiver: stall on a repeating 16-bit ready pattern. Pick a fresh pattern each
  // round: sometimes no stall at all, sometimes a hold for the whole round, else random.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: stall_pattern = 16'hFFFF;
        3:       stall_pattern = 16'h0000;
        default: stall_pattern = 16'($urandom);
      endcase
    end
    out_ch.ready <= stall_pattern[stall_phase];
    stall_phase = (stall_phase + 1) % 16;
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. Note the input word
  // first so that a same-edge output word always finds its prediction.
  // The watchdog ends the run after too many cycles with no word moving.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    speed_word_t got;
    logic        moved;
    moved = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      wheels.take_tick(cmd_t'(in_ch.cmd), in_ch.angle_right, in_ch.angle_left);
      ticks_by_cmd[in_ch.cmd]++;
      moved = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.speed_right = out_ch.speed_right;
      got.speed_left  = out_ch.speed_left;
      got.knob_number = out_ch.knob_number;
      got.knob_mode   = out_ch.knob_mode;
      wheels.match_word(got);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks. Every task starts and ends at a falling edge, so valid gets
  // at most one assignment per time step.
  // --------------------------------------------------------------------------

  // Present one tick and hold it until the block takes it.
  task send_tick(cmd_t c, logic [ANGLE_BITS-1:0] ar, logic [ANGLE_BITS-1:0] al);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.angle_right <= ar;
    in_ch.angle_left  <= al;
    pos_right = ar;
    pos_left  = al;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid for the given gap; a zero gap leaves valid untouched.
  task idle(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every owed word has come back.
  task drain();
    idle(1);
    while (wheels.owed_words.size() != 0) @(negedge clk);
  endtask

  // Write all four registers, one per cycle, while the block is idle.
  task apply_settings(logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] deadband,
                      logic [CFG_DATA_W-1:0] unwrap_thr, logic [CFG_DATA_W-1:0] knob_thr);
    logic [CFG_DATA_W-1:0] vals [4];
    vals[REG_SPEED_GAIN] = gain;
    vals[REG_DEADBAND]   = deadband;
    vals[REG_UNWRAP_THR] = unwrap_thr;
    vals[REG_KNOB_THR]   = knob_thr;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      wheels.write_reg(cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly slow motion; sometimes fast enough to step knobs; rarely up to nearly a
  // full turn so the unwrap threshold comes into play.
  function automatic int pick_velocity();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return int'($urandom_range(0, 1200)) - 600;
    if (r < 9) return int'($urandom_range(0, 16000)) - 8000;
    return int'($urandom_range(0, 32766)) - 16383;
  endfunction

  // Random traffic: wheels move at a velocity that changes now and then,
  // with a share of noise ticks at arbitrary angles. Send in bursts.
  task run_traffic(int n_ticks);
    int                    vr;
    int                    vl;
    int                    burst;
    int                    roll;
    logic [ANGLE_BITS-1:0] ar;
    logic [ANGLE_BITS-1:0] al;
    cmd_t                  c;
    vr    = pick_velocity();
    vl    = pick_velocity();
    burst = 0;
    for (int sent = 0; sent < n_ticks; sent++) begin
      if (burst == 0) begin
        idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        burst = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 30);
      end
      if ($urandom_range(0, 15) == 0) vr = pick_velocity();
      if ($urandom_range(0, 15) == 0) vl = pick_velocity();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        ar = ANGLE_BITS'($urandom);
        al = ANGLE_BITS'($urandom);
      end else begin
        ar = pos_right + ANGLE_BITS'(vr);
        al = pos_left + ANGLE_BITS'(vl);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      c = CMD_SAMPLE;
      else if (roll < 90) c = CMD_SAMPLE_KNOB;
      else if (roll < 95) c = CMD_CLEAR;
      else                c = CMD_NONE;
      send_tick(c, ar, al);
      burst--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    wheels            = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_SAMPLE;
    in_ch.angle_right = '0;
    in_ch.angle_left  = '0;
    out_ch.ready      = 1'b0;
    pos_right         = '0;
    pos_left          = '0;
    settings_used     = 1;
    idle_cycles       = 0;
    for (int i = 0; i < 4; i++) ticks_by_cmd[i] = 0;

    // Hold reset, then release it at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed ticks under the reset settings.
    // First tick runs against angle zero: right's raw jump of nearly a full turn unwraps to one count back.
    send_tick(CMD_SAMPLE, 14'h3FFF, 14'h0000);
    // Unused command: nothing moves, current values come back.
    send_tick(CMD_NONE, 14'h1555, 14'h2AAA);
    // Wrap on both wheels while counting knobs: right forward, left back.
    send_tick(CMD_SAMPLE_KNOB, 14'h0000, 14'h3FFF);
    // Deadband edge: right moves one count short, left exactly at it.
    send_tick(CMD_SAMPLE_KNOB, 14'd29, 14'd16353);
    // Delta exactly at the unwrap threshold stays as is and steps both knobs.
    send_tick(CMD_SAMPLE_KNOB, 14'd13682, 14'd2700);
    send_tick(CMD_SAMPLE, 14'd0, 14'd0);
    // One count past the threshold gets unwrapped.
    send_tick(CMD_SAMPLE, 14'd13654, 14'd13654);
    // Clear takes no sample even with angles present.
    send_tick(CMD_CLEAR, 14'h3FFF, 14'h3FFF);
    // Spin forward then backward far enough to step each knob both ways.
    for (int k = 0; k < 4; k++)
      send_tick(CMD_SAMPLE_KNOB, pos_right + 14'd8000, pos_left + 14'd8000);
    for (int k = 0; k < 4; k++)
      send_tick(CMD_SAMPLE_KNOB, pos_right - 14'd8000, pos_left - 14'd8000);
    send_tick(CMD_CLEAR, 14'h0000, 14'h0000);
    // Toggle every angle bit.
    for (int k = 0; k < 6; k++)
      send_tick(CMD_SAMPLE, k[0] ? 14'h2AAA : 14'h1555, k[0] ? 14'h1555 : 14'h2AAA);

    run_traffic(200);
    drain();

    // Largest gain with no deadband: speeds saturate, knobs step on any motion.
    apply_settings(24'hFFFFFF, 24'd0, 24'd16383, 24'd0);
    run_traffic(200);
    drain();

    // Largest deadband: only saturated speeds survive; unwrap on any motion.
    apply_settings(24'hFFFFFF, 24'h7FFF, 24'd0, 24'd16383);
    run_traffic(200);
    drain();

    // Zero gain: averages stay at zero while knobs still count.
    apply_settings(24'd0, 24'd0, 24'd8192, 24'd1);
    run_traffic(150);
    drain();

    // Realistic wheel settings.
    apply_settings(CFG_DATA_W'($urandom_range(1000, 400000)),
                   CFG_DATA_W'($urandom_range(0, 200)),
                   CFG_DATA_W'($urandom_range(4096, 16383)),
                   CFG_DATA_W'($urandom_range(64, 16383)));
    run_traffic(250);
    drain();

    // Anything the registers can hold.
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'(15'($urandom)),
                   CFG_DATA_W'(14'($urandom)), CFG_DATA_W'(14'($urandom)));
    run_traffic(200);
    drain();

    // Back to the reset values.
    apply_settings(CFG_DATA_W'(GAIN_RST), CFG_DATA_W'(DEADBAND_RST),
                   CFG_DATA_W'(UNWRAP_RST), CFG_DATA_W'(KNOB_RST));
    run_traffic(250);
    drain();

    // Let any stray word show up before the verdict.
    repeat (16) @(negedge clk);

    $display("Covered %0d ticks (%0d sample, %0d sample+knob, %0d clear, %0d unused cmd)",
             ticks_by_cmd[0] + ticks_by_cmd[1] + ticks_by_cmd[2] + ticks_by_cmd[3],
             ticks_by_cmd[0], ticks_by_cmd[1], ticks_by_cmd[2], ticks_by_cmd[3]);
    $display("over %0d register settings; %0d words checked, %0d mismatches",
             settings_used, wheels.words_checked, wheels.mismatch_count);
    if (wheels.mismatch_count == 0 && wheels.owed_words.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
